/* hw/rtl/fdtw_pkg.sv */
// ----------------------------------------------------------------------------
// fdtw_pkg
// Shared types and constants for the device tree structure word walker.
// ----------------------------------------------------------------------------
`default_nettype none

package fdtw_pkg;

    localparam int DEPTH_BITS  = 8;
    localparam int DEPTH_OUT_W = 8;
    localparam int LEFT_W      = 30;

    localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
    localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
    localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
    localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [31:0] TOK_END        = 32'h0000_0009;

    typedef enum logic [2:0] {
        KIND_IGNORED  = 3'd0,
        KIND_BEGIN    = 3'd1,
        KIND_NAME     = 3'd2,
        KIND_PROP     = 3'd3,
        KIND_VALUE    = 3'd4,
        KIND_NOP      = 3'd5,
        KIND_END_NODE = 3'd6,
        KIND_END      = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_CLOSE_ZERO = 2'd1,
        ERR_END_EARLY  = 2'd2,
        ERR_OVERFLOW   = 2'd3
    } error_t;

    typedef enum logic [2:0] {
        PH_TOKEN    = 3'd0,
        PH_NAME     = 3'd1,
        PH_PROP_LEN = 3'd2,
        PH_PROP_OFF = 3'd3,
        PH_VALUE    = 3'd4
    } phase_t;

endpackage

`default_nettype wire

/* hw/rtl/fdtw_if.sv */
// ----------------------------------------------------------------------------
// fdtw_if
// Valid/ready channels for structure block words and classified results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdtw_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink   (input valid, input word, input last_word, output ready);
endinterface

interface fdtw_result_if import fdtw_pkg::*;;
    logic                   valid;
    logic                   ready;
    kind_t                  kind;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [31:0]            data;
    logic                   string_last;
    logic [31:0]            prop_length;
    logic [31:0]            name_offset;
    error_t                 error;
    logic                   done_res;

    modport source (
        output valid, output kind, output depth, output data, output string_last,
        output prop_length, output name_offset, output error, output done_res,
        input ready
    );
    modport sink (
        input valid, input kind, input depth, input data, input string_last,
        input prop_length, input name_offset, input error, input done_res,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/fdt_struct_token_walker.sv */
// ----------------------------------------------------------------------------
// fdt_struct_token_walker
// Classifies each word of a flattened device tree structure block.
// ----------------------------------------------------------------------------
// One word enters per cycle and one result word leaves per word, in the
// cycle after it is taken, through a single output register; the walker
// state (phase, nesting depth, end-node flag, value word count) updates
// in the same cycle the word is taken, so that rate holds as long as the
// result side keeps taking words. A structural error or an end token
// stops the walk: later words report as ignored with done_res set until
// the word marked last_word, which returns the walker to its reset state.
`default_nettype none

module fdt_struct_token_walker import fdtw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    fdtw_word_if.sink         stream,
    fdtw_result_if.source     result
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    phase_t                phase_reg,   phase_next;
    logic [DEPTH_BITS-1:0] nest_reg,    nest_next;
    logic                  aen_reg,     aen_next;
    logic [LEFT_W-1:0]     left_reg,    left_next;
    logic [31:0]           held_reg,    held_next;
    logic                  stopped_reg, stopped_next;

    logic                   out_valid_reg;
    kind_t                  kind_reg;
    logic [DEPTH_OUT_W-1:0] depth_reg;
    logic [31:0]            data_reg;
    logic                   slast_reg;
    logic [31:0]            plen_reg;
    logic [31:0]            noff_reg;
    error_t                 err_reg;
    logic                   done_reg;

    kind_t       kind_c;
    logic [31:0] data_c;
    logic        slast_c;
    logic [31:0] plen_c;
    logic [31:0] noff_c;
    error_t      err_c;
    logic        done_c;
    logic [DEPTH_OUT_W-1:0] depth_c;
    logic        zero_byte;
    logic        in_fire;

    assign stream.ready = !out_valid_reg || result.ready;
    assign in_fire      = stream.valid && stream.ready;

    assign zero_byte = (stream.word[31:24] == 8'h00) || (stream.word[23:16] == 8'h00) ||
                       (stream.word[15:8] == 8'h00)  || (stream.word[7:0] == 8'h00);

    always_comb
    begin
        phase_next   = phase_reg;
        nest_next    = nest_reg;
        aen_next     = aen_reg;
        left_next    = left_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        kind_c       = KIND_IGNORED;
        data_c       = '0;
        slast_c      = 1'b0;
        plen_c       = '0;
        noff_c       = '0;
        err_c        = ERR_NONE;

        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_NAME:
                begin
                    kind_c = KIND_NAME;
                    data_c = stream.word;
                    if (zero_byte)
                    begin
                        slast_c    = 1'b1;
                        phase_next = PH_TOKEN;
                    end
                end
                PH_PROP_LEN:
                begin
                    kind_c     = KIND_PROP;
                    held_next  = stream.word;
                    plen_c     = stream.word;
                    phase_next = PH_PROP_OFF;
                end
                PH_PROP_OFF:
                begin
                    kind_c = KIND_PROP;
                    plen_c = held_reg;
                    noff_c = stream.word;
                    if (held_reg == 32'd0)
                    begin
                        phase_next = PH_TOKEN;
                    end
                    else
                    begin
                        left_next  = LEFT_W'((held_reg - 32'd1) >> 2);
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    kind_c = KIND_VALUE;
                    data_c = stream.word;
                    if (left_reg == '0)
                    begin
                        phase_next = PH_TOKEN;
                    end
                    else
                    begin
                        left_next = left_reg - LEFT_W'(1);
                    end
                end
                default:
                begin
                    aen_next   = 1'b0;
                    phase_next = PH_TOKEN;
                    case (stream.word)
                        TOK_BEGIN_NODE:
                        begin
                            kind_c = KIND_BEGIN;
                            if (nest_reg == DEPTH_MAX)
                            begin
                                err_c        = ERR_OVERFLOW;
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                nest_next  = nest_reg + DEPTH_BITS'(1);
                                phase_next = PH_NAME;
                            end
                        end
                        TOK_PROP:
                        begin
                            kind_c     = KIND_PROP;
                            held_next  = '0;
                            phase_next = PH_PROP_LEN;
                        end
                        TOK_NOP:
                        begin
                            kind_c = KIND_NOP;
                        end
                        TOK_END_NODE:
                        begin
                            kind_c = KIND_END_NODE;
                            if (nest_reg == '0)
                            begin
                                err_c        = ERR_CLOSE_ZERO;
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                nest_next = nest_reg - DEPTH_BITS'(1);
                                aen_next  = 1'b1;
                            end
                        end
                        TOK_END:
                        begin
                            kind_c = KIND_END;
                            if (!aen_reg)
                            begin
                                err_c = ERR_END_EARLY;
                            end
                            stopped_next = 1'b1;
                        end
                        default:
                        begin
                            kind_c = KIND_IGNORED;
                        end
                    endcase
                end
            endcase
        end

        depth_c = DEPTH_OUT_W'(nest_next);
        done_c  = stopped_next || stream.last_word;

        if (stream.last_word)
        begin
            phase_next   = PH_TOKEN;
            nest_next    = '0;
            aen_next     = 1'b0;
            left_next    = '0;
            held_next    = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOKEN;
            nest_reg    <= '0;
            aen_reg     <= 1'b0;
            left_reg    <= '0;
            held_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            nest_reg    <= nest_next;
            aen_reg     <= aen_next;
            left_reg    <= left_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            out_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= kind_c;
            depth_reg <= depth_c;
            data_reg  <= data_c;
            slast_reg <= slast_c;
            plen_reg  <= plen_c;
            noff_reg  <= noff_c;
            err_reg   <= err_c;
            done_reg  <= done_c;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.depth       = depth_reg;
    assign result.data        = data_reg;
    assign result.string_last = slast_reg;
    assign result.prop_length = plen_reg;
    assign result.name_offset = noff_reg;
    assign result.error       = err_reg;
    assign result.done_res    = done_reg;

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg != ERR_NONE) |-> done_reg)
        else $error("error word without done");

    a_stopped_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && stopped_reg) |=> (kind_reg == KIND_IGNORED && done_reg))
        else $error("stopped walker classified a word");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && stream.last_word) |=>
            (phase_reg == PH_TOKEN && nest_reg == '0 && !stopped_reg && !aen_reg))
        else $error("last word did not reset walker");

    a_slast_name: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && slast_reg) |-> (kind_reg == KIND_NAME))
        else $error("string end flag on non-name word");

endmodule

`default_nettype wire
